### design/gtc_pkg.sv
// Shared types and constants for the glass TTY text controller.
// No dependencies; gtc_ctrl, gtc_datapath and the top refer to it by scoped names.
package gtc_pkg;

    // Character codes, judged on the low 7 bits
    localparam logic [6:0] CHAR_BS     = 7'h08;
    localparam logic [6:0] CHAR_TAB    = 7'h09;
    localparam logic [6:0] CHAR_LF     = 7'h0A;
    localparam logic [6:0] CHAR_FF     = 7'h0C;
    localparam logic [6:0] CHAR_CR     = 7'h0D;
    localparam logic [6:0] CHAR_HOME   = 7'h1E;
    localparam logic [6:0] CTRL_LIMIT  = 7'h20;
    localparam logic [7:0] SPACE_CHAR  = 8'h20;
    localparam logic       FUNC_READ   = 1'b1;

    typedef enum logic [2:0] {
        ST_BOOT,
        ST_IDLE,
        ST_EXEC,
        ST_READ,
        ST_COPY,
        ST_FILL,
        ST_CLEAR,
        ST_FINISH
    } gtc_state_t;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_READ,
        OP_PRINT,
        OP_BS,
        OP_TAB,
        OP_LF,
        OP_FF,
        OP_CR,
        OP_HOME
    } gtc_op_t;

    typedef struct packed {
        logic load;           // latch input item
        logic exec;           // apply decoded op to cursor / memory
        logic capture;        // take read data into the result
        logic init_copy;      // start scroll copy sweep
        logic init_fill_row;  // start bottom row fill
        logic init_clear;     // start full screen fill
        logic copy_step;      // one scroll copy step
        logic fill_step;      // one space write step
        logic finish;         // load output register
    } gtc_cmd_t;

    typedef struct packed {
        gtc_op_t op;
        logic    scroll;       // op needs a scroll
        logic    cnt_at_end;   // sweep counter at cell count
        logic    cnt_at_last;  // sweep counter at last cell
        logic    slot_free;    // output register can take a result
    } gtc_status_t;

endpackage

### design/gtc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module gtc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1920
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### design/gtc_ctrl.sv
// Control state machine: sequences the boot fill, item execution, scroll and clear sweeps.
// Depends on gtc_pkg.
module gtc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  gtc_pkg::gtc_status_t status,
    output gtc_pkg::gtc_cmd_t    cmd
);

    gtc_pkg::gtc_state_t state_reg;
    gtc_pkg::gtc_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gtc_pkg::ST_BOOT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            gtc_pkg::ST_BOOT:
            begin
                cmd.fill_step = 1'b1;
                if (status.cnt_at_last)
                begin
                    state_next = gtc_pkg::ST_IDLE;
                end
            end
            gtc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = gtc_pkg::ST_EXEC;
                end
            end
            gtc_pkg::ST_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.op == gtc_pkg::OP_READ)
                begin
                    state_next = gtc_pkg::ST_READ;
                end
                else if (status.op == gtc_pkg::OP_FF)
                begin
                    cmd.init_clear = 1'b1;
                    state_next     = gtc_pkg::ST_CLEAR;
                end
                else if (status.scroll)
                begin
                    cmd.init_copy = 1'b1;
                    state_next    = gtc_pkg::ST_COPY;
                end
                else
                begin
                    state_next = gtc_pkg::ST_FINISH;
                end
            end
            gtc_pkg::ST_READ:
            begin
                cmd.capture = 1'b1;
                state_next  = gtc_pkg::ST_FINISH;
            end
            gtc_pkg::ST_COPY:
            begin
                cmd.copy_step = 1'b1;
                if (status.cnt_at_end)
                begin
                    cmd.init_fill_row = 1'b1;
                    state_next        = gtc_pkg::ST_FILL;
                end
            end
            gtc_pkg::ST_FILL,
            gtc_pkg::ST_CLEAR:
            begin
                cmd.fill_step = 1'b1;
                if (status.cnt_at_last)
                begin
                    state_next = gtc_pkg::ST_FINISH;
                end
            end
            gtc_pkg::ST_FINISH:
            begin
                if (status.slot_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = gtc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gtc_pkg::ST_IDLE;
            end
        endcase
    end

    assign in_stall = (state_reg != gtc_pkg::ST_IDLE);

endmodule

### design/gtc_datapath.sv
// Datapath: item latch, decode, cursor, sweep counter, screen RAM, result register.
// Depends on gtc_pkg and gtc_ram.
module gtc_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gtc_pkg::gtc_cmd_t    cmd,
    output gtc_pkg::gtc_status_t status,
    input  logic                 func,
    input  logic [7:0]           char_code,
    input  logic [10:0]          cell_address,
    input  logic                 out_stall,
    output logic                 out_valid,
    output logic [6:0]           cursor_column,
    output logic [4:0]           cursor_row,
    output logic [7:0]           cell_data
);

    localparam int CW    = $clog2(COLUMNS);
    localparam int CXW   = CW + 1;
    localparam int RW    = $clog2(ROWS);
    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CNTW  = $clog2(CELLS + 1);

    // Item latch (payload)
    logic        func_reg;
    logic [7:0]  char_reg;
    logic [10:0] addr_reg;

    // Cursor and sweep counter (control)
    logic [CW-1:0]   col_reg, col_next;
    logic [RW-1:0]   row_reg, row_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;

    // Result
    logic [7:0] data_reg;
    logic       out_valid_reg, out_valid_next;
    logic [6:0] out_col_reg;
    logic [4:0] out_row_reg;
    logic [7:0] out_cell_reg;

    // Decode and cursor arithmetic
    logic [6:0]      code;
    gtc_pkg::gtc_op_t op;
    logic [CXW-1:0]  col_ext, col_inc, tab_col;
    logic            wrap_print, wrap_tab, at_bottom, in_range;
    logic [RW-1:0]   row_lf;
    logic [AW-1:0]   print_addr;
    logic [CNTW-1:0] copy_dst;

    // RAM ports
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    always_comb
    begin
        code = char_reg[6:0];
        if (func_reg == gtc_pkg::FUNC_READ)
        begin
            op = gtc_pkg::OP_READ;
        end
        else if (code >= gtc_pkg::CTRL_LIMIT)
        begin
            op = gtc_pkg::OP_PRINT;
        end
        else
        begin
            case (code)
                gtc_pkg::CHAR_BS:   op = gtc_pkg::OP_BS;
                gtc_pkg::CHAR_TAB:  op = gtc_pkg::OP_TAB;
                gtc_pkg::CHAR_LF:   op = gtc_pkg::OP_LF;
                gtc_pkg::CHAR_FF:   op = gtc_pkg::OP_FF;
                gtc_pkg::CHAR_CR:   op = gtc_pkg::OP_CR;
                gtc_pkg::CHAR_HOME: op = gtc_pkg::OP_HOME;
                default:            op = gtc_pkg::OP_NOP;
            endcase
        end
    end

    assign col_ext    = CXW'(col_reg);
    assign col_inc    = col_ext + CXW'(1);
    assign tab_col    = (col_ext + CXW'(8)) & ~CXW'(7);
    assign wrap_print = (col_inc >= CXW'(COLUMNS));
    assign wrap_tab   = (tab_col >= CXW'(COLUMNS));
    assign at_bottom  = (row_reg == RW'(ROWS - 1));
    assign row_lf     = at_bottom ? row_reg : row_reg + RW'(1);
    assign in_range   = (32'(addr_reg) < CELLS);
    assign print_addr = AW'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign copy_dst   = cnt_reg - CNTW'(COLUMNS + 1);

    // Cursor update on exec
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (cmd.exec)
        begin
            case (op)
                gtc_pkg::OP_PRINT:
                begin
                    if (wrap_print)
                    begin
                        col_next = '0;
                        row_next = row_lf;
                    end
                    else
                    begin
                        col_next = col_inc[CW-1:0];
                    end
                end
                gtc_pkg::OP_BS:
                begin
                    if (col_reg != '0)
                    begin
                        col_next = col_reg - CW'(1);
                    end
                    else
                    begin
                        col_next = CW'(COLUMNS - 1);
                        if (row_reg != '0)
                        begin
                            row_next = row_reg - RW'(1);
                        end
                    end
                end
                gtc_pkg::OP_TAB:
                begin
                    if (wrap_tab)
                    begin
                        col_next = '0;
                        row_next = row_lf;
                    end
                    else
                    begin
                        col_next = tab_col[CW-1:0];
                    end
                end
                gtc_pkg::OP_LF:
                begin
                    row_next = row_lf;
                end
                gtc_pkg::OP_FF,
                gtc_pkg::OP_HOME:
                begin
                    col_next = '0;
                    row_next = '0;
                end
                gtc_pkg::OP_CR:
                begin
                    col_next = '0;
                end
                default:
                begin
                    col_next = col_reg;
                end
            endcase
        end
    end

    // Sweep counter
    always_comb
    begin
        cnt_next = cnt_reg;
        if (cmd.init_clear)
        begin
            cnt_next = '0;
        end
        else if (cmd.init_copy)
        begin
            cnt_next = CNTW'(COLUMNS);
        end
        else if (cmd.init_fill_row)
        begin
            cnt_next = CNTW'(CELLS - COLUMNS);
        end
        else if (cmd.copy_step || cmd.fill_step)
        begin
            cnt_next = cnt_reg + CNTW'(1);
        end
    end

    // RAM port selection; copy writes, one row up, the data read by the previous copy step
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = print_addr;
        ram_wdata = char_reg;
        ram_raddr = AW'(addr_reg);
        if (cmd.copy_step)
        begin
            ram_raddr = cnt_reg[AW-1:0];
            ram_waddr = copy_dst[AW-1:0];
            ram_wdata = ram_rdata;
            ram_we    = (cnt_reg > CNTW'(COLUMNS));
        end
        else if (cmd.fill_step)
        begin
            ram_waddr = cnt_reg[AW-1:0];
            ram_wdata = gtc_pkg::SPACE_CHAR;
            ram_we    = 1'b1;
        end
        else if (cmd.exec && op == gtc_pkg::OP_PRINT)
        begin
            ram_we = 1'b1;
        end
    end

    gtc_ram #(
        .WIDTH (8),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_valid_next = cmd.finish ? 1'b1 : (out_valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg       <= col_next;
            row_reg       <= row_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= func;
            char_reg <= char_code;
            addr_reg <= cell_address;
        end
        if (cmd.exec)
        begin
            data_reg <= 8'h00;
        end
        else if (cmd.capture)
        begin
            data_reg <= in_range ? ram_rdata : 8'h00;
        end
        if (cmd.finish)
        begin
            out_col_reg  <= 7'(col_reg);
            out_row_reg  <= 5'(row_reg);
            out_cell_reg <= data_reg;
        end
    end

    assign status.op          = op;
    assign status.scroll      = at_bottom && ((op == gtc_pkg::OP_LF)
                                || (op == gtc_pkg::OP_TAB && wrap_tab)
                                || (op == gtc_pkg::OP_PRINT && wrap_print));
    assign status.cnt_at_end  = (cnt_reg == CNTW'(CELLS));
    assign status.cnt_at_last = (cnt_reg == CNTW'(CELLS - 1));
    assign status.slot_free   = !out_valid_reg || !out_stall;

    assign out_valid     = out_valid_reg;
    assign cursor_column = out_col_reg;
    assign cursor_row    = out_row_reg;
    assign cell_data     = out_cell_reg;

endmodule

### design/glass_tty_text_controller_top.sv
// Glass TTY text controller top: controller FSM + datapath with screen RAM.
// One item at a time; an LF or wrap at the bottom row adds a scroll, and FF adds a full
// screen clear. The next item is accepted once the result is registered.
// Reset: clears cursor and control; then a pass writes spaces to every screen RAM cell
// with in_stall high. Depends on gtc_pkg, gtc_ctrl, gtc_datapath.
module glass_tty_text_controller_top #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 24
) (
    input  logic        clk,
    input  logic        rst_n,
    // input item channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        func,
    input  logic [7:0]  char_code,
    input  logic [10:0] cell_address,
    // result item channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [6:0]  cursor_column,
    output logic [4:0]  cursor_row,
    output logic [7:0]  cell_data
);

    // Command/status link between control and datapath
    gtc_pkg::gtc_cmd_t    cmd;
    gtc_pkg::gtc_status_t status;

    // Control: one item in flight; scroll is a copy sweep (read the row below, write it
    // one row up on the next copy step) followed by a space fill of the bottom row.
    gtc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath: cursor arithmetic, screen RAM port muxing, result register.
    // The result register lets a finished item wait while the next is taken.
    gtc_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .func          (func),
        .char_code     (char_code),
        .cell_address  (cell_address),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .cursor_column (cursor_column),
        .cursor_row    (cursor_row),
        .cell_data     (cell_data)
    );

`ifndef ASSERT_OFF
    // One item at a time: an accepted item blocks input on the next cycle
    a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted while an item is in flight");

    // Latched item is executed right after it is taken
    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("loaded item not executed");

    // A result never overwrites one still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> (!out_valid || !out_stall))
        else $error("result register overwritten");

    // Reported cursor column stays on the screen
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (32'(cursor_column) < COLUMNS))
        else $error("cursor column out of range");
`endif

endmodule
